/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge of clk while out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never be true while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* hw/rtl/nfa_pkg.sv */
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared constants and types of the next-fit identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfa_pkg;

    // Identifier space and bitmap organization.
    localparam int ID_COUNT = 4096;
    localparam int ID_W     = 12;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int ROWS     = ID_COUNT / WORD_W;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int VISIT_W  = $clog2(ROWS + 1);

    // Request modes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_BAD_ID    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    // Controller -> datapath.
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic eval;
        logic finish;
    } cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/nfa_ram.sv */
// ----------------------------------------------------------------------------
// nfa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/nfa_ctrl.sv */
// ----------------------------------------------------------------------------
// nfa_ctrl
// Sequencer: accept, read a bitmap row, evaluate it, repeat or finish.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire nfa_pkg::stat_t stat,
    output nfa_pkg::cmd_t       cmd
);

    nfa_pkg::state_t state_reg;
    nfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nfa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nfa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nfa_pkg::S_READ;
                end
            end
            nfa_pkg::S_READ:
            begin
                state_next = nfa_pkg::S_EVAL;
            end
            nfa_pkg::S_EVAL:
            begin
                state_next = stat.done ? nfa_pkg::S_FINISH : nfa_pkg::S_READ;
            end
            nfa_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = nfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            nfa_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            nfa_pkg::S_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            nfa_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            nfa_pkg::S_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/nfa_dpath.sv */
// ----------------------------------------------------------------------------
// nfa_dpath
// Bitmap rows, row valid bits, search pointer, find-first and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module nfa_dpath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire nfa_pkg::cmd_t            cmd,
    output nfa_pkg::stat_t                stat,
    input  wire logic [1:0]               mode,
    input  wire logic [nfa_pkg::ID_W-1:0] ident,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [nfa_pkg::ID_W-1:0] result_ident,
    output logic                          in_use,
    output logic      [1:0]               status
);

    // Request and scan state
    logic [1:0]                    mode_reg;
    logic [nfa_pkg::ID_W-1:0]      ident_reg;
    logic [nfa_pkg::ROW_W-1:0]     row_reg, row_next;
    logic                          first_reg, first_next;
    logic [nfa_pkg::VISIT_W-1:0]   visits_reg, visits_next;
    logic [nfa_pkg::ID_W-1:0]      ptr_reg, ptr_next;
    logic [nfa_pkg::ROWS-1:0]      row_valid_reg, row_valid_next;

    // Pending result and output beat
    logic [nfa_pkg::ID_W-1:0]      pend_ident_reg, pend_ident_next;
    logic                          pend_in_use_reg, pend_in_use_next;
    logic [1:0]                    pend_status_reg, pend_status_next;
    logic                          out_valid_reg, out_valid_next;
    logic [nfa_pkg::ID_W-1:0]      res_ident_reg;
    logic                          in_use_reg;
    logic [1:0]                    status_reg;

    // Bitmap RAM
    logic                          wr_en;
    logic [nfa_pkg::WORD_W-1:0]    wr_data;
    logic [nfa_pkg::WORD_W-1:0]    rd_data;

    // Evaluation
    logic [nfa_pkg::WORD_W-1:0]    row_word;
    logic [nfa_pkg::WORD_W-1:0]    low_mask;
    logic [nfa_pkg::WORD_W-1:0]    avail;
    logic [nfa_pkg::BIT_W-1:0]     hit_idx;
    logic                          hit;
    logic [nfa_pkg::ID_W-1:0]      found_id;
    logic [nfa_pkg::ID_W-1:0]      ptr_after;
    logic [nfa_pkg::BIT_W-1:0]     id_bit;
    logic                          id_ok;
    logic                          lap_done;
    logic                          is_alloc;
    logic                          done;

    nfa_ram #(
        .WIDTH (nfa_pkg::WORD_W),
        .DEPTH (nfa_pkg::ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (row_reg),
        .rd_data (rd_data)
    );

    // Row lookup, masking and find-first-free
    always_comb
    begin
        row_word = row_valid_reg[row_reg] ? rd_data : '0;
        low_mask = first_reg ? ({nfa_pkg::WORD_W{1'b1}} << ptr_reg[nfa_pkg::BIT_W-1:0])
                             : {nfa_pkg::WORD_W{1'b1}};
        avail    = ~row_word & low_mask;
        if (row_reg == '0)
        begin
            avail[0] = 1'b0;   // id zero is never handed out
        end
        hit_idx = '0;
        for (int i = nfa_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                hit_idx = nfa_pkg::BIT_W'(i);
            end
        end
        hit       = |avail;
        found_id  = {row_reg, hit_idx};
        ptr_after = (found_id == nfa_pkg::ID_W'(nfa_pkg::ID_COUNT - 1))
                    ? nfa_pkg::ID_W'(1) : found_id + nfa_pkg::ID_W'(1);
        id_bit    = ident_reg[nfa_pkg::BIT_W-1:0];
        id_ok     = (ident_reg != '0) && (int'(ident_reg) < nfa_pkg::ID_COUNT);
        lap_done  = (visits_reg == nfa_pkg::VISIT_W'(nfa_pkg::ROWS));
        is_alloc  = (mode_reg == nfa_pkg::MODE_ALLOC);
        done      = !is_alloc || hit || lap_done;
    end

    always_comb
    begin
        wr_en   = cmd.eval && ((is_alloc && hit) || (mode_reg == nfa_pkg::MODE_FREE && id_ok));
        wr_data = is_alloc ? (row_word | (nfa_pkg::WORD_W'(1) << hit_idx))
                           : (row_word & ~(nfa_pkg::WORD_W'(1) << id_bit));
    end

    // Next-state of scan and result registers
    always_comb
    begin
        row_next         = row_reg;
        first_next       = first_reg;
        visits_next      = visits_reg;
        ptr_next         = ptr_reg;
        row_valid_next   = row_valid_reg;
        pend_ident_next  = pend_ident_reg;
        pend_in_use_next = pend_in_use_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;

        if (cmd.accept)
        begin
            row_next    = (mode == nfa_pkg::MODE_ALLOC) ? ptr_reg[nfa_pkg::ID_W-1:nfa_pkg::BIT_W]
                                                        : ident[nfa_pkg::ID_W-1:nfa_pkg::BIT_W];
            first_next  = 1'b1;
            visits_next = '0;
        end

        if (cmd.eval)
        begin
            if (!done)
            begin
                row_next    = row_reg + nfa_pkg::ROW_W'(1);
                first_next  = 1'b0;
                visits_next = visits_reg + nfa_pkg::VISIT_W'(1);
            end
            if (is_alloc && hit)
            begin
                ptr_next = ptr_after;
            end
            if (wr_en)
            begin
                row_valid_next[row_reg] = 1'b1;
            end
            if (done)
            begin
                pend_ident_next  = ident_reg;
                pend_in_use_next = 1'b0;
                pend_status_next = id_ok ? nfa_pkg::ST_OK : nfa_pkg::ST_BAD_ID;
                case (mode_reg)
                    nfa_pkg::MODE_ALLOC:
                    begin
                        pend_ident_next  = hit ? found_id : '0;
                        pend_status_next = hit ? nfa_pkg::ST_OK : nfa_pkg::ST_EXHAUSTED;
                    end
                    nfa_pkg::MODE_FREE:
                    begin
                        pend_in_use_next = 1'b0;
                    end
                    nfa_pkg::MODE_QUERY:
                    begin
                        pend_in_use_next = id_ok && row_word[id_bit];
                    end
                    default:
                    begin
                        pend_status_next = nfa_pkg::ST_BAD_ID;
                    end
                endcase
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= nfa_pkg::ID_W'(1);
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg  <= mode;
            ident_reg <= ident;
        end
        row_reg         <= row_next;
        first_reg       <= first_next;
        visits_reg      <= visits_next;
        pend_ident_reg  <= pend_ident_next;
        pend_in_use_reg <= pend_in_use_next;
        pend_status_reg <= pend_status_next;
        if (cmd.finish)
        begin
            res_ident_reg <= pend_ident_reg;
            in_use_reg    <= pend_in_use_reg;
            status_reg    <= pend_status_reg;
        end
    end

    assign stat.done     = done;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign result_ident = res_ident_reg;
    assign in_use       = in_use_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

/* hw/rtl/next_fit_id_allocator_unit.sv */
// ----------------------------------------------------------------------------
// next_fit_id_allocator_unit
// Next-fit identifier allocator over a 4096-bit occupancy bitmap.
// ----------------------------------------------------------------------------
// Hands out identifiers 1..4095. Each input beat carries a mode (0 allocate,
// 1 free, 2 query) and an ident; each produces exactly one output beat with
// result_ident, in_use and status (0 ok, 1 exhausted, 2 bad identifier).
// Allocation is next-fit: a search pointer (1 after reset) marks where the
// scan starts, and after a hit it points just past the returned identifier,
// wrapping from 4095 to 1. When no identifier is free the beat reports
// exhaustion with id 0 and the pointer is left where it was. The bitmap is
// kept as 128 rows of 32 bits in a RAM with registered read; each row has a
// valid flop cleared by reset, and a row that was never written reads as all
// free, so the block is usable right out of reset with no clearing pass.
// One item is in flight at a time. Free, query and an allocation that hits in
// its first row pass the read, evaluate and finish states on the way to the
// output beat; each further row scanned adds a RAM read and a find-first
// evaluate; a full exhausted lap makes 129 row visits. A finished beat waits
// in the output register while the downstream side stalls, and a new input
// beat is taken once that result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module next_fit_id_allocator_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               mode,
    input  wire logic [nfa_pkg::ID_W-1:0] ident,
    // result channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [nfa_pkg::ID_W-1:0] result_ident,
    output logic                          in_use,
    output logic      [1:0]               status
);

    nfa_pkg::cmd_t  cmd;
    nfa_pkg::stat_t stat;

    // Sequencer
    nfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Bitmap, pointer and result registers
    nfa_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .ident        (ident),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_ident (result_ident),
        .in_use       (in_use),
        .status       (status)
    );

    // An exhausted allocation always returns id zero.
    `ASSERT_PROP(a_exhausted_zero, clk, rst_n,
        (out_valid && status == nfa_pkg::ST_EXHAUSTED) |-> result_ident == '0)

    // in_use is only reported for a good, nonzero identifier.
    `ASSERT_PROP(a_in_use_ok, clk, rst_n,
        (out_valid && in_use) |-> (status == nfa_pkg::ST_OK && result_ident != '0))

    // Only one item in flight: an accepted beat closes the input side.
    `ASSERT_PROP(a_busy_after_accept, clk, rst_n,
        (in_valid && !in_stall) |=> in_stall)

endmodule

`default_nettype wire
